/* rtl/crg_pkg.sv */
// shared types, constants and rate table for the clock and reset generator
`timescale 1ns / 1ps

package crg_pkg;

	localparam int TABLE_ENTRIES = 16;

	localparam int RATE_W = 4;
	localparam int PRE_W  = 10;
	localparam int PER_W  = 16;
	localparam int HOLD_W = 26;
	localparam int MODE_W = 2;
	localparam int STAT_W = 2;
	localparam int CFG_W  = 26;
	localparam int CIDX_W = 2;

	localparam logic [HOLD_W-1:0] HOLD_TICKS_RESET = HOLD_W'(48000000);

	// configuration register indexes
	localparam logic [CIDX_W-1:0] CFG_RESET_MODE   = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_INITIAL_RATE = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_HOLD_TICKS   = 2'd2;

	// reset_mode bit positions
	localparam int MODE_ACTIVE_HIGH = 0;
	localparam int MODE_MANUAL      = 1;

	// reset status codes
	localparam logic [STAT_W-1:0] STAT_RUNNING = 2'd0;
	localparam logic [STAT_W-1:0] STAT_POWERUP = 2'd1;
	localparam logic [STAT_W-1:0] STAT_BUTTON  = 2'd2;

	typedef enum logic [2:0] {
		PH_RUN     = 3'b001,
		PH_POWERUP = 3'b010,
		PH_BUTTON  = 3'b100
	} phase_t;

	typedef struct packed {
		logic [RATE_W-1:0] rate;
		logic              clock_level;
	} rate_stat_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic              level;
	} rst_stat_t;

	function automatic logic [PRE_W-1:0] rom_pre(input logic [RATE_W-1:0] r);
		logic [PRE_W-1:0] v;
		case (r)
			4'd0:    v = PRE_W'(749);
			4'd1:    v = PRE_W'(149);
			4'd2:    v = PRE_W'(74);
			4'd3:    v = PRE_W'(14);
			4'd4:    v = PRE_W'(7);
			4'd5:    v = PRE_W'(1);
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic logic [PER_W-1:0] rom_div(input logic [RATE_W-1:0] r);
		logic [PER_W-1:0] v;
		case (r)
			4'd0, 4'd1, 4'd2, 4'd3: v = PER_W'(63999);
			4'd4:    v = PER_W'(59999);
			4'd5, 4'd6: v = PER_W'(47999);
			4'd7:    v = PER_W'(9599);
			4'd8:    v = PER_W'(4799);
			4'd9:    v = PER_W'(959);
			4'd10:   v = PER_W'(479);
			4'd11:   v = PER_W'(95);
			4'd12:   v = PER_W'(47);
			4'd13:   v = PER_W'(23);
			4'd14:   v = PER_W'(11);
			default: v = PER_W'(5);
		endcase
		return v;
	endfunction

	function automatic logic [RATE_W-1:0] clamp_rate(input logic [RATE_W-1:0] r);
		return (int'(r) >= TABLE_ENTRIES) ? '0 : r;
	endfunction

	function automatic logic [RATE_W-1:0] next_rate(input logic [RATE_W-1:0] r);
		return (int'(r) + 1 >= TABLE_ENTRIES || r == '1) ? '0 : r + RATE_W'(1);
	endfunction

endpackage

/* rtl/crg_rate.sv */
// rate index with prescale and period counters, generated clock level
`timescale 1ns / 1ps

module crg_rate (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic                        left,
	input  logic                        load,
	input  logic [crg_pkg::RATE_W-1:0]  load_rate,
	output crg_pkg::rate_stat_t         stat
);

	logic [crg_pkg::RATE_W-1:0] rate_q;
	logic [crg_pkg::PRE_W-1:0]  pre_q;
	logic [crg_pkg::PER_W-1:0]  per_q;
	logic [crg_pkg::PRE_W-1:0]  pre_lim;
	logic [crg_pkg::PER_W-1:0]  div_lim;

	assign pre_lim = crg_pkg::rom_pre(rate_q);
	assign div_lim = crg_pkg::rom_div(rate_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= '0;
			pre_q  <= '0;
			per_q  <= '0;
		end else if (load) begin
			rate_q <= crg_pkg::clamp_rate(load_rate);
			pre_q  <= '0;
			per_q  <= '0;
		end else if (step) begin
			if (left) begin
				rate_q <= crg_pkg::next_rate(rate_q);
				pre_q  <= '0;
				per_q  <= '0;
			end else if (pre_q >= pre_lim) begin
				pre_q <= '0;
				per_q <= (per_q >= div_lim) ? '0 : per_q + crg_pkg::PER_W'(1);
			end else begin
				pre_q <= pre_q + crg_pkg::PRE_W'(1);
			end
		end
	end

	assign stat.rate        = rate_q;
	assign stat.clock_level = (per_q < (div_lim >> 1));

endmodule

/* rtl/crg_reset.sv */
// reset phase sequencer with hold counter and pin polarity
`timescale 1ns / 1ps

module crg_reset (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic                        right,
	input  logic [crg_pkg::MODE_W-1:0]  mode,
	input  logic [crg_pkg::HOLD_W-1:0]  hold_ticks,
	output crg_pkg::rst_stat_t          stat
);

	crg_pkg::phase_t            phase_q, phase_n;
	logic [crg_pkg::HOLD_W-1:0] hold_q, hold_n;

	always_comb begin
		logic                       press;
		logic [crg_pkg::HOLD_W-1:0] hinc;
		press   = right;
		phase_n = phase_q;
		hold_n  = hold_q;
		hinc    = hold_q + crg_pkg::HOLD_W'(1);
		if (phase_q == crg_pkg::PH_POWERUP && mode[crg_pkg::MODE_MANUAL]) begin
			// manual release consumes the press
			if (press) begin
				phase_n = crg_pkg::PH_RUN;
				hold_n  = '0;
				press   = 1'b0;
			end
		end else if (phase_q != crg_pkg::PH_RUN) begin
			// zero hold_ticks releases after one tick like a value of one
			if (hinc >= hold_ticks) begin
				phase_n = crg_pkg::PH_RUN;
				hold_n  = '0;
			end else begin
				hold_n = hinc;
			end
		end
		if (press) begin
			phase_n = crg_pkg::PH_BUTTON;
			hold_n  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= crg_pkg::PH_POWERUP;
			hold_q  <= '0;
		end else if (step) begin
			phase_q <= phase_n;
			hold_q  <= hold_n;
		end
	end

	always_comb begin
		case (phase_q)
			crg_pkg::PH_RUN:     stat.status = crg_pkg::STAT_RUNNING;
			crg_pkg::PH_POWERUP: stat.status = crg_pkg::STAT_POWERUP;
			crg_pkg::PH_BUTTON:  stat.status = crg_pkg::STAT_BUTTON;
			default:             stat.status = crg_pkg::STAT_RUNNING;
		endcase
		stat.level = (phase_q != crg_pkg::PH_RUN) ? mode[crg_pkg::MODE_ACTIVE_HIGH]
		                                          : ~mode[crg_pkg::MODE_ACTIVE_HIGH];
	end

endmodule

/* rtl/clock_and_reset_generator_top.sv */
// clock and reset generator: config registers, tick handshake and result register
//
//  channel | valid      | stall      | payload
//  --------+------------+------------+------------------------------------------------
//  in      | in_valid   | in_stall   | right_press, left_press
//  out     | out_valid  | out_stall  | clock_level, reset_level, rate_now, reset_status
//  cfg     | cfg_we     | -          | cfg_index, cfg_data
//
// one tick per cycle unless in_stall; each transfer in gives a result the next cycle
// the result shows the state before the tick, the tick's update lands in the counters
// in_stall is high only while a held result is stalled at the output
// after reset: rate 0, counters clear, power-up hold, hold_ticks 48000000
`timescale 1ns / 1ps

module clock_and_reset_generator_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        right_press,
	input  logic                        left_press,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        clock_level,
	output logic                        reset_level,
	output logic [crg_pkg::RATE_W-1:0]  rate_now,
	output logic [crg_pkg::STAT_W-1:0]  reset_status,
	input  logic                        cfg_we,
	input  logic [crg_pkg::CIDX_W-1:0]  cfg_index,
	input  logic [crg_pkg::CFG_W-1:0]   cfg_data
);

	logic [crg_pkg::MODE_W-1:0] mode_q;
	logic [crg_pkg::HOLD_W-1:0] hold_ticks_q;
	logic                       out_valid_q;
	logic                       accept;
	logic                       load_rate;
	crg_pkg::rate_stat_t        rate_stat;
	crg_pkg::rst_stat_t         rst_stat;

	assign in_stall  = out_valid_q && out_stall;
	assign accept    = in_valid && !in_stall;
	assign load_rate = cfg_we && (cfg_index == crg_pkg::CFG_INITIAL_RATE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= '0;
			hold_ticks_q <= crg_pkg::HOLD_TICKS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				crg_pkg::CFG_RESET_MODE: mode_q       <= cfg_data[crg_pkg::MODE_W-1:0];
				crg_pkg::CFG_HOLD_TICKS: hold_ticks_q <= cfg_data[crg_pkg::HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	crg_rate u_rate (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (accept),
		.left      (left_press),
		.load      (load_rate),
		.load_rate (cfg_data[crg_pkg::RATE_W-1:0]),
		.stat      (rate_stat)
	);

	crg_reset u_reset (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (accept),
		.right      (right_press),
		.mode       (mode_q),
		.hold_ticks (hold_ticks_q),
		.stat       (rst_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload, captured with each transfer in
	always_ff @(posedge clk) begin
		if (accept) begin
			clock_level  <= rate_stat.clock_level;
			reset_level  <= rst_stat.level;
			rate_now     <= rate_stat.rate;
			reset_status <= rst_stat.status;
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* sim/crg_tick_checker.sv */
// checker for the clock and reset generator: tracks config writes, predicts each tick, compares results
`timescale 1ns / 1ps

module crg_tick_checker
	import crg_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic              right_press,
	input  logic              left_press,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic              clock_level,
	input  logic              reset_level,
	input  logic [RATE_W-1:0] rate_now,
	input  logic [STAT_W-1:0] reset_status,
	input  logic              cfg_we,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	output int                failures,
	output int                outstanding
);

	typedef struct packed {
		logic              clock_level;
		logic              reset_level;
		logic [RATE_W-1:0] rate_now;
		logic [STAT_W-1:0] reset_status;
	} tick_result_t;

	tick_result_t expected_ticks[$];

	// register copies
	logic [MODE_W-1:0] mode_reg;
	logic [HOLD_W-1:0] hold_limit;

	// generator state
	logic [RATE_W-1:0] cur_rate;
	logic [PRE_W-1:0]  pre_cnt;
	logic [PER_W-1:0]  per_cnt;
	logic [STAT_W-1:0] rst_phase;
	logic [HOLD_W-1:0] hold_cnt;

	function automatic logic [PRE_W-1:0] prescale_limit(input logic [RATE_W-1:0] r);
		case (r)
			4'd0: return PRE_W'(749);
			4'd1: return PRE_W'(149);
			4'd2: return PRE_W'(74);
			4'd3: return PRE_W'(14);
			4'd4: return PRE_W'(7);
			4'd5: return PRE_W'(1);
			default: return '0;
		endcase
	endfunction

	function automatic logic [PER_W-1:0] period_limit(input logic [RATE_W-1:0] r);
		case (r)
			4'd0, 4'd1, 4'd2, 4'd3: return PER_W'(63999);
			4'd4: return PER_W'(59999);
			4'd5, 4'd6: return PER_W'(47999);
			4'd7: return PER_W'(9599);
			4'd8: return PER_W'(4799);
			4'd9: return PER_W'(959);
			4'd10: return PER_W'(479);
			4'd11: return PER_W'(95);
			4'd12: return PER_W'(47);
			4'd13: return PER_W'(23);
			4'd14: return PER_W'(11);
			default: return PER_W'(5);
		endcase
	endfunction

	// result shows the state before the tick, then the state moves on
	function automatic tick_result_t predict_tick(input logic rp, input logic lp);
		tick_result_t res;
		logic [PRE_W-1:0] pre_lim;
		logic [PER_W-1:0] per_lim;
		logic active_high;
		logic press;
		pre_lim = prescale_limit(cur_rate);
		per_lim = period_limit(cur_rate);
		active_high = mode_reg[MODE_ACTIVE_HIGH];
		press = rp;
		res.clock_level  = (per_cnt < (per_lim >> 1));
		res.reset_level  = (rst_phase != STAT_RUNNING) ? active_high : !active_high;
		res.rate_now     = cur_rate;
		res.reset_status = rst_phase;

		if (rst_phase == STAT_POWERUP && mode_reg[MODE_MANUAL]) begin
			// manual power-up: the press is used up by the release
			if (press) begin
				rst_phase = STAT_RUNNING;
				hold_cnt = '0;
				press = 1'b0;
			end
		end else if (rst_phase != STAT_RUNNING) begin
			hold_cnt = hold_cnt + HOLD_W'(1);
			if (hold_cnt >= hold_limit) begin
				rst_phase = STAT_RUNNING;
				hold_cnt = '0;
			end
		end

		if (press) begin
			rst_phase = STAT_BUTTON;
			hold_cnt = '0;
		end

		if (lp) begin
			if (int'(cur_rate) + 1 >= TABLE_ENTRIES || &cur_rate)
				cur_rate = '0;
			else
				cur_rate = cur_rate + RATE_W'(1);
			pre_cnt = '0;
			per_cnt = '0;
		end else if (pre_cnt >= pre_lim) begin
			pre_cnt = '0;
			if (per_cnt >= per_lim)
				per_cnt = '0;
			else
				per_cnt = per_cnt + PER_W'(1);
		end else begin
			pre_cnt = pre_cnt + PRE_W'(1);
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		tick_result_t got;
		tick_result_t want;
		if (!arst_n) begin
			mode_reg = '0;
			hold_limit = HOLD_TICKS_RESET;
			cur_rate = '0;
			pre_cnt = '0;
			per_cnt = '0;
			rst_phase = STAT_POWERUP;
			hold_cnt = '0;
			expected_ticks.delete();
			failures = 0;
			outstanding = 0;
		end else begin
			// output side first: a result never belongs to a tick taken at the same edge
			if (out_valid && !out_stall) begin
				got = {clock_level, reset_level, rate_now, reset_status};
				if (expected_ticks.size() == 0) begin
					failures++;
					if (failures <= 10)
						$display("[%0t] result with no tick pending: clk %0b rst %0b rate %0d status %0d",
							$time, got.clock_level, got.reset_level, got.rate_now, got.reset_status);
				end else begin
					want = expected_ticks.pop_front();
					if (got !== want) begin
						failures++;
						if (failures <= 10)
							$display("[%0t] mismatch clk/rst/rate/stat: exp %0b/%0b/%0d/%0d got %0b/%0b/%0d/%0d",
								$time,
								want.clock_level, want.reset_level, want.rate_now, want.reset_status,
								got.clock_level, got.reset_level, got.rate_now, got.reset_status);
					end
				end
			end

			if (cfg_we) begin
				case (cfg_index)
					CFG_RESET_MODE: mode_reg = cfg_data[MODE_W-1:0];
					CFG_INITIAL_RATE: begin
						cur_rate = (int'(cfg_data[RATE_W-1:0]) >= TABLE_ENTRIES) ?
							'0 : cfg_data[RATE_W-1:0];
						pre_cnt = '0;
						per_cnt = '0;
					end
					CFG_HOLD_TICKS: hold_limit = cfg_data[HOLD_W-1:0];
					default: ;
				endcase
			end

			if (in_valid && !in_stall)
				expected_ticks.push_back(predict_tick(right_press, left_press));
			outstanding = expected_ticks.size();
		end
	end

endmodule

/* sim/tb_top.sv */
// testbench top for the clock and reset generator: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_top;
	import crg_pkg::*;

	localparam logic [CIDX_W-1:0] CFG_SPARE = 2'd3;
	localparam int CYCLE_LIMIT       = 600000;
	localparam int RAND_SETTINGS     = 8;
	localparam int TICKS_PER_SETTING = 250;
	localparam int LONG_HOLD         = 300;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic              right_press;
	logic              left_press;
	logic              out_valid;
	logic              out_stall;
	logic              clock_level;
	logic              reset_level;
	logic [RATE_W-1:0] rate_now;
	logic [STAT_W-1:0] reset_status;
	logic              cfg_we;
	logic [CIDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]  cfg_data;
	int                failures;
	int                outstanding;

	int ticks_sent;
	int settings_used;
	bit tx_quiet;

	clock_and_reset_generator_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.right_press(right_press),
		.left_press(left_press),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.clock_level(clock_level),
		.reset_level(reset_level),
		.rate_now(rate_now),
		.reset_status(reset_status),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	crg_tick_checker tick_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.right_press(right_press),
		.left_press(left_press),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.clock_level(clock_level),
		.reset_level(reset_level),
		.rate_now(rate_now),
		.reset_status(reset_status),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.failures(failures),
		.outstanding(outstanding)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// field value in the low bits, random junk above it
	function automatic logic [CFG_W-1:0] pad_field(input int width, input int value);
		logic [CFG_W-1:0] mask;
		mask = (CFG_W'(1) << width) - CFG_W'(1);
		return (CFG_W'($urandom) & ~mask) | (CFG_W'(value) & mask);
	endfunction

	// one tick transfer, entered and left at a falling edge
	task automatic send_tick(input logic rp, input logic lp);
		int gap;
		if ($urandom_range(0, 39) == 0)
			tx_quiet = !tx_quiet;
		gap = tx_quiet ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		right_press <= rp;
		left_press <= lp;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		ticks_sent++;
		@(negedge clk);
	endtask

	// registers change only with no tick in flight
	task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		in_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// result side: random stalls, quiet stretches, and two long hold-offs
	initial begin : result_sink
		int wait_n;
		int taken;
		bit quiet;
		out_stall = 1'b0;
		taken = 0;
		quiet = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 39) == 0)
				quiet = !quiet;
			if (taken == 600 || taken == 1400)
				wait_n = LONG_HOLD;
			else
				wait_n = quiet ? 0 : $urandom_range(0, 17);
			if (wait_n > 0) begin
				out_stall <= 1'b1;
				repeat (wait_n) @(negedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			taken++;
			@(negedge clk);
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles", cycles);
		$display("simulation failed");
		$finish;
	end

	initial begin : stimulus
		logic rp;
		logic lp;
		int right_pct;
		int left_pct;
		logic [CFG_W-1:0] hold_val;
		in_valid = 1'b0;
		right_press = 1'b0;
		left_press = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		ticks_sent = 0;
		settings_used = 0;
		tx_quiet = 1'b0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// power-up hold with reset values, then switched live to manual release
		repeat (3) send_tick(1'b0, 1'b0);
		write_reg(CFG_RESET_MODE, pad_field(MODE_W, 1 << MODE_MANUAL));
		send_tick(1'b0, 1'b1);
		send_tick(1'b0, 1'b1);
		send_tick(1'b1, 1'b1);   // release only, no new button hold
		send_tick(1'b0, 1'b0);

		// zero hold acts as one tick, top rate wraps, hold restarts on repeated press
		write_reg(CFG_HOLD_TICKS, '0);
		write_reg(CFG_INITIAL_RATE, pad_field(RATE_W, 15));
		write_reg(CFG_RESET_MODE, pad_field(MODE_W, 1 << MODE_ACTIVE_HIGH));
		send_tick(1'b1, 1'b0);
		send_tick(1'b0, 1'b0);
		send_tick(1'b1, 1'b0);
		send_tick(1'b1, 1'b0);
		send_tick(1'b0, 1'b0);
		send_tick(1'b0, 1'b1);
		send_tick(1'b0, 1'b0);

		// short timed hold, and a write to the unused index that must change nothing
		write_reg(CFG_HOLD_TICKS, CFG_W'(3));
		write_reg(CFG_INITIAL_RATE, pad_field(RATE_W, 14));
		write_reg(CFG_SPARE, CFG_W'($urandom));
		send_tick(1'b1, 1'b0);
		repeat (3) send_tick(1'b0, 1'b0);
		send_tick(1'b1, 1'b1);
		send_tick(1'b0, 1'b1);
		send_tick(1'b0, 1'b0);
		settings_used = 3;

		for (int p = 0; p < RAND_SETTINGS; p++) begin
			write_reg(CFG_RESET_MODE, pad_field(MODE_W, p % 4));
			if (p == 0)
				write_reg(CFG_INITIAL_RATE, pad_field(RATE_W, 15));
			else if (p == 1)
				write_reg(CFG_INITIAL_RATE, pad_field(RATE_W, 0));
			else
				write_reg(CFG_INITIAL_RATE, pad_field(RATE_W, $urandom_range(0, 15)));
			if (p == 2)
				hold_val = '1;
			else if (p == 5)
				hold_val = '0;
			else
				hold_val = CFG_W'($urandom_range(1, 40));
			write_reg(CFG_HOLD_TICKS, hold_val);
			settings_used++;

			right_pct = $urandom_range(1, 6);
			left_pct = (p % 3 == 0) ? 0 : $urandom_range(1, 6);
			for (int n = 0; n < TICKS_PER_SETTING; n++) begin
				if ($urandom_range(0, 9) == 0) begin
					// press noise
					rp = $urandom_range(0, 1);
					lp = $urandom_range(0, 1);
				end else begin
					rp = ($urandom_range(0, 99) < right_pct);
					lp = ($urandom_range(0, 99) < left_pct);
				end
				send_tick(rp, lp);
			end
		end

		in_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (10) @(negedge clk);

		$display("%0d ticks over %0d register settings, random gaps, stalls and long hold-offs",
			ticks_sent, settings_used);
		$display("covered manual and timed release, zero and max hold, rate wrap, live mode changes");
		if (failures == 0 && outstanding == 0) begin
			$display("simulation ok");
		end else begin
			if (outstanding != 0)
				$display("%0d expected results never arrived", outstanding);
			$display("simulation failed");
		end
		$finish;
	end

endmodule

/* filelist.f */
rtl/crg_pkg.sv
rtl/crg_rate.sv
rtl/crg_reset.sv
rtl/clock_and_reset_generator_top.sv
sim/crg_tick_checker.sv
sim/tb_top.sv
